// File: src/gbc_pkg.sv
// Shared types and constants for the gap buffer cursor engine.
// No dependencies; used by gbc_ctrl, the top level and the testbench.
package gbc_pkg;

    localparam int DEF_CAPACITY = 4096;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    localparam logic [2:0] ACT_APPEND = 3'd0;
    localparam logic [2:0] ACT_LEFT   = 3'd1;
    localparam logic [2:0] ACT_RIGHT  = 3'd2;
    localparam logic [2:0] ACT_UP     = 3'd3;
    localparam logic [2:0] ACT_DOWN   = 3'd4;
    localparam logic [2:0] ACT_DELETE = 3'd5;
    localparam logic [2:0] ACT_INSERT = 3'd6;
    localparam logic [2:0] ACT_READ   = 3'd7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NO_DEL   = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [12:0] count;
        logic [7:0]  data_byte;
        logic [11:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic [12:0] column;
        logic [7:0]  before_byte;
        logic [7:0]  after_byte;
        logic        before_empty;
        logic        after_empty;
        logic [12:0] text_length;
        logic [7:0]  read_byte;
        logic [1:0]  status;
    } t_out_item;

endpackage

// File: src/gbc_text_ram.sv
// Text store of the gap buffer: one write port, one read port, registered read data.
// Depends on nothing.
module gbc_text_ram #(
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [2**AW];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/gbc_ctrl.sv
// Sequencer of the gap buffer: cursor registers, byte-by-byte moves across the gap,
// column scan and result register. Depends on gbc_pkg; drives gbc_text_ram.
module gbc_ctrl #(
    parameter int CAPACITY = gbc_pkg::DEF_CAPACITY,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  gbc_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output gbc_pkg::t_out_item o_item,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output logic [7:0]         o_wdata,
    output logic [AW-1:0]      o_raddr,
    input  logic [7:0]         i_rdata
);
    import gbc_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > 13) ? LW : 13;
    localparam int IW = (LW > 12) ? LW : 12;
    localparam logic [LW-1:0] CAP = LW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_FILL, S_APR, S_APW, S_DELR, S_RD, S_COL, S_COLW, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        P_LEFT, P_RIGHT, P_LS1, P_BACK, P_LS2, P_FWD, P_SEEK, P_OVER, P_FWDNL
    } t_phase;

    t_state      r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [LW-1:0] r_before, n_before;
    logic [LW-1:0] r_after, n_after;
    logic [LW-1:0] r_column, n_column;
    logic [LW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]  r_bb, n_bb;
    logic [7:0]  r_ab, n_ab;
    logic [7:0]  r_data, n_data;
    logic [7:0]  r_rbyte, n_rbyte;
    logic [1:0]  r_status, n_status;
    logic        r_fill_ab, n_fill_ab;
    logic        r_ov, n_ov;
    t_out_item   r_out, n_out;

    logic [LW-1:0] w_total, w_af, w_rel;
    logic [IW-1:0] w_idx;
    logic          w_have_b, w_have_a, w_cnt_z, w_step_l, w_step_r, w_to_col;

    assign w_total  = r_before + r_after;
    assign w_af     = CAP - r_after;
    assign w_have_b = (r_before != '0);
    assign w_have_a = (r_after != '0);
    assign w_cnt_z  = (r_cnt == '0);
    assign w_idx    = IW'(i_item.read_index);
    assign w_rel    = LW'(w_idx - IW'(r_before));

    // Decide which single step (if any) the current phase wants.
    always_comb begin
        w_step_l = 1'b0;
        w_step_r = 1'b0;
        w_to_col = 1'b0;
        n_phase  = r_phase;
        unique case (r_phase)
            P_LEFT: begin
                w_step_l = !w_cnt_z && w_have_b;
                w_to_col = !w_step_l;
            end
            P_RIGHT, P_FWD: begin
                w_step_r = !w_cnt_z && w_have_a;
                w_to_col = !w_step_r;
            end
            P_LS1: begin
                w_step_l = w_have_b && (r_bb != NEWLINE_BYTE);
                if (!w_step_l) n_phase = P_BACK;
            end
            P_BACK: begin
                w_step_l = w_have_b;
                n_phase  = P_LS2;
            end
            P_LS2: begin
                w_step_l = w_have_b && (r_bb != NEWLINE_BYTE);
                if (!w_step_l) n_phase = P_FWD;
            end
            P_SEEK: begin
                w_step_r = w_have_a && (r_ab != NEWLINE_BYTE);
                if (!w_step_r) n_phase = P_OVER;
            end
            P_OVER: begin
                w_step_r = w_have_a;
                n_phase  = P_FWDNL;
            end
            P_FWDNL: begin
                w_step_r = !w_cnt_z && w_have_a && (r_ab != NEWLINE_BYTE);
                w_to_col = !w_step_r;
            end
            default: begin
                w_to_col = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_before  = r_before;
        n_after   = r_after;
        n_column  = r_column;
        n_ptr     = r_ptr;
        n_cnt     = r_cnt;
        n_bb      = r_bb;
        n_ab      = r_ab;
        n_data    = r_data;
        n_rbyte   = r_rbyte;
        n_status  = r_status;
        n_fill_ab = r_fill_ab;
        n_ov      = r_ov && !i_ready;
        n_out     = r_out;
        o_we      = 1'b0;
        o_waddr   = '0;
        o_wdata   = '0;
        o_raddr   = '0;
        o_ready   = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_status = ST_OK;
                    n_rbyte  = '0;
                    n_data   = i_item.data_byte;
                    n_state  = S_DONE;
                    unique case (i_item.action)
                        ACT_APPEND: begin
                            if (w_total == CAP) begin
                                n_status = ST_FULL;
                            end else begin
                                n_ptr   = w_af;
                                n_state = S_APR;
                            end
                        end
                        ACT_LEFT, ACT_RIGHT: begin
                            n_cnt   = CW'(i_item.count);
                            n_state = S_DECIDE;
                        end
                        ACT_UP, ACT_DOWN: begin
                            n_cnt   = CW'(r_column);
                            n_state = S_DECIDE;
                        end
                        ACT_DELETE: begin
                            if (!w_have_a) begin
                                n_status = ST_NO_DEL;
                            end else begin
                                n_after = r_after - 1'b1;
                                o_raddr = AW'(w_af + 1'b1);
                                n_state = S_DELR;
                            end
                        end
                        ACT_INSERT: begin
                            if (w_total == CAP) begin
                                n_status = ST_FULL;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = AW'(w_af - 1'b1);
                                o_wdata = i_item.data_byte;
                                n_after = r_after + 1'b1;
                                n_ab    = i_item.data_byte;
                            end
                        end
                        default: begin
                            if (w_idx >= IW'(w_total)) begin
                                n_status = ST_RANGE;
                            end else begin
                                o_raddr = (w_idx < IW'(r_before)) ? AW'(w_idx)
                                                                  : AW'(w_af + w_rel);
                                n_state = S_RD;
                            end
                        end
                    endcase
                end
            end
            S_DECIDE: begin
                if (w_step_l) begin
                    // The byte left of the cursor crosses the gap; refetch the new left byte.
                    o_we      = 1'b1;
                    o_waddr   = AW'(w_af - 1'b1);
                    o_wdata   = r_bb;
                    o_raddr   = AW'(r_before - 2'd2);
                    n_ab      = r_bb;
                    n_before  = r_before - 1'b1;
                    n_after   = r_after + 1'b1;
                    n_fill_ab = 1'b0;
                    n_state   = S_FILL;
                end else if (w_step_r) begin
                    o_we      = 1'b1;
                    o_waddr   = AW'(r_before);
                    o_wdata   = r_ab;
                    o_raddr   = AW'(w_af + 1'b1);
                    n_bb      = r_ab;
                    n_before  = r_before + 1'b1;
                    n_after   = r_after - 1'b1;
                    n_fill_ab = 1'b1;
                    n_state   = S_FILL;
                end else if (w_to_col) begin
                    n_ptr   = '0;
                    n_state = S_COL;
                end
                if ((w_step_l || w_step_r) && (r_phase == P_LEFT || r_phase == P_RIGHT ||
                        r_phase == P_FWD || r_phase == P_FWDNL)) begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_FILL: begin
                if (r_fill_ab) n_ab = i_rdata;
                else           n_bb = i_rdata;
                n_state = S_DECIDE;
            end
            S_APR: begin
                if (r_ptr == CAP) begin
                    o_we    = 1'b1;
                    o_waddr = AW'(CAP - 1'b1);
                    o_wdata = r_data;
                    n_after = r_after + 1'b1;
                    if (!w_have_a) n_ab = r_data;
                    n_state = S_DONE;
                end else begin
                    o_raddr = AW'(r_ptr);
                    n_state = S_APW;
                end
            end
            S_APW: begin
                o_we    = 1'b1;
                o_waddr = AW'(r_ptr - 1'b1);
                o_wdata = i_rdata;
                n_ptr   = r_ptr + 1'b1;
                n_state = S_APR;
            end
            S_DELR: begin
                n_ab    = i_rdata;
                n_state = S_DONE;
            end
            S_RD: begin
                n_rbyte = i_rdata;
                n_state = S_DONE;
            end
            S_COL: begin
                if (r_ptr == r_before) begin
                    n_column = r_ptr;
                    n_state  = S_DONE;
                end else begin
                    o_raddr = AW'(r_before - 1'b1 - r_ptr);
                    n_state = S_COLW;
                end
            end
            S_COLW: begin
                if (i_rdata == NEWLINE_BYTE) begin
                    n_column = r_ptr;
                    n_state  = S_DONE;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = S_COL;
                end
            end
            default: begin
                if (!r_ov || i_ready) begin
                    n_out.column       = 13'(r_column);
                    n_out.before_byte  = w_have_b ? r_bb : 8'd0;
                    n_out.after_byte   = w_have_a ? r_ab : 8'd0;
                    n_out.before_empty = !w_have_b;
                    n_out.after_empty  = !w_have_a;
                    n_out.text_length  = 13'(w_total);
                    n_out.read_byte    = r_rbyte;
                    n_out.status       = r_status;
                    n_ov               = 1'b1;
                    n_state            = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= P_LEFT;
            r_before <= '0;
            r_after  <= '0;
            r_column <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_before <= n_before;
            r_after  <= n_after;
            r_column <= n_column;
            r_ov     <= n_ov;
            if (r_state == S_IDLE && i_valid) begin
                unique case (i_item.action)
                    ACT_LEFT:                       r_phase <= P_LEFT;
                    ACT_RIGHT:                      r_phase <= P_RIGHT;
                    ACT_UP:                         r_phase <= P_LS1;
                    ACT_DOWN:                       r_phase <= P_SEEK;
                    default:                        r_phase <= r_phase;
                endcase
            end else if (r_state == S_DECIDE) begin
                r_phase <= n_phase;
            end
        end
        r_ptr     <= n_ptr;
        r_cnt     <= n_cnt;
        r_bb      <= n_bb;
        r_ab      <= n_ab;
        r_data    <= n_data;
        r_rbyte   <= n_rbyte;
        r_status  <= n_status;
        r_fill_ab <= n_fill_ab;
        r_out     <= n_out;
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

    a_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_before} + {1'b0, r_after}) <= (LW + 1)'(CAPACITY))
        else $error("gap buffer holds more bytes than its capacity");

    // The column is only rescanned at the end of a move, so it is checked between requests.
    a_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_column <= r_before))
        else $error("cursor column exceeds bytes left of cursor");

    a_no_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE || r_state == S_FILL || r_state == S_COL) |-> !o_we)
        else $error("text store written outside a write step");

    a_len_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && !w_step_l && !w_step_r) |=> $stable(r_before))
        else $error("cursor moved without a step");
endmodule

// File: src/gap_buffer_cursor_engine_top.sv
// Gap buffer cursor engine: a text buffer of CAPACITY bytes with a cursor, held as a
// gap buffer in one single-port-write, registered-read RAM. Requests are taken one at a
// time. Insert writes at once, refused or out-of-range requests write nothing, and
// delete and read add one RAM read. Append shifts each byte right of the cursor down
// one at a time, a read then a write each, through the RAM read latency. Moves step
// bytes across the gap one at a time, refetching each new neighbour, then scan the
// column back to the previous newline. Results sit in an output register; a result is
// registered once the last is taken; the next request follows. Depends on gbc_pkg.
module gap_buffer_cursor_engine_top #(
    parameter int CAPACITY = gbc_pkg::DEF_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  gbc_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output gbc_pkg::t_out_item o_item
);
    import gbc_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [7:0]    w_wdata, w_rdata;

    gbc_ctrl #(.CAPACITY(CAPACITY), .AW(AW)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item),
        .o_we    (w_we),
        .o_waddr (w_waddr),
        .o_wdata (w_wdata),
        .o_raddr (w_raddr),
        .i_rdata (w_rdata)
    );

    gbc_text_ram #(.AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );
endmodule

// File: dv/tb_gap_buffer_cursor_engine_top.sv
// Self-checking testbench for the gap buffer cursor engine top level.
// Requests go in and results come out with random bursts and stalls. Each result is
// compared with a text model of the block. Depends on gbc_pkg and the block RTL.
module tb_gap_buffer_cursor_engine_top;
    import gbc_pkg::*;

    localparam int CAP        = DEF_CAPACITY;
    localparam int IDLE_LIMIT = 200000;
    localparam int N_RANDOM   = 500;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_item;

    gap_buffer_cursor_engine_top #(.CAPACITY(CAP)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_item (i_item),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_item (o_item)
    );

    // Text model: left side at the low end, right side at the high end.
    logic [7:0] text_mem [CAP];
    int         head_len;
    int         right_len;
    int         cur_col;

    t_in_item  pending_reqs [$];
    t_out_item expected_results [$];
    int        mismatches;
    int        idle_cycles;
    bit        req_taken;
    int        burst_left;
    int        gap_left;
    int        stall_mode;
    int        stall_timer;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [7:0] byte_left();
        return (head_len > 0) ? text_mem[head_len - 1] : 8'h00;
    endfunction

    function automatic logic [7:0] byte_right();
        return (right_len > 0) ? text_mem[CAP - right_len] : 8'h00;
    endfunction

    function automatic void shift_left_one();
        if (head_len == 0) return;
        text_mem[CAP - right_len - 1] = text_mem[head_len - 1];
        head_len--;
        right_len++;
    endfunction

    function automatic void shift_right_one();
        if (right_len == 0) return;
        text_mem[head_len] = text_mem[CAP - right_len];
        head_len++;
        right_len--;
    endfunction

    function automatic void seek_line_start();
        while (head_len > 0 && byte_left() != NEWLINE_BYTE) shift_left_one();
    endfunction

    function automatic void rescan_column();
        int n;
        n = 0;
        while (n < head_len && text_mem[head_len - 1 - n] != NEWLINE_BYTE) n++;
        cur_col = n;
    endfunction

    function automatic t_out_item apply_edit(t_in_item req);
        t_out_item res;
        int total;
        int old_col;
        int i;
        logic [1:0] st;
        logic [7:0] rb;
        total = head_len + right_len;
        old_col = cur_col;
        st = ST_OK;
        rb = 8'h00;
        case (req.action)
            ACT_APPEND: begin
                if (total >= CAP) begin
                    st = ST_FULL;
                end else begin
                    for (i = CAP - right_len - 1; i < CAP - 1; i++) text_mem[i] = text_mem[i + 1];
                    text_mem[CAP - 1] = req.data_byte;
                    right_len++;
                end
            end
            ACT_LEFT: begin
                for (i = 0; i < int'(req.count) && head_len > 0; i++) shift_left_one();
                rescan_column();
            end
            ACT_RIGHT: begin
                for (i = 0; i < int'(req.count) && right_len > 0; i++) shift_right_one();
                rescan_column();
            end
            ACT_UP: begin
                seek_line_start();
                shift_left_one();
                seek_line_start();
                for (i = 0; i < old_col && right_len > 0; i++) shift_right_one();
                rescan_column();
            end
            ACT_DOWN: begin
                while (right_len > 0 && byte_right() != NEWLINE_BYTE) shift_right_one();
                shift_right_one();
                for (i = 0; i < old_col && right_len > 0 && byte_right() != NEWLINE_BYTE; i++)
                    shift_right_one();
                rescan_column();
            end
            ACT_DELETE: begin
                if (right_len == 0) st = ST_NO_DEL;
                else right_len--;
            end
            ACT_INSERT: begin
                if (total >= CAP) begin
                    st = ST_FULL;
                end else begin
                    text_mem[CAP - right_len - 1] = req.data_byte;
                    right_len++;
                end
            end
            default: begin
                if (int'(req.read_index) >= total) st = ST_RANGE;
                else if (int'(req.read_index) < head_len) rb = text_mem[req.read_index];
                else rb = text_mem[CAP - right_len + (int'(req.read_index) - head_len)];
            end
        endcase
        res.column       = 13'(cur_col);
        res.before_byte  = byte_left();
        res.after_byte   = byte_right();
        res.before_empty = (head_len == 0);
        res.after_empty  = (right_len == 0);
        res.text_length  = 13'(head_len + right_len);
        res.read_byte    = rb;
        res.status       = st;
        return res;
    endfunction

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // Results are checked before the request of the same edge is modeled.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("column", want.column, o_item.column);
                    check_field("before_byte", want.before_byte, o_item.before_byte);
                    check_field("after_byte", want.after_byte, o_item.after_byte);
                    check_field("before_empty", want.before_empty, o_item.before_empty);
                    check_field("after_empty", want.after_empty, o_item.after_empty);
                    check_field("text_length", want.text_length, o_item.text_length);
                    check_field("read_byte", want.read_byte, o_item.read_byte);
                    check_field("status", want.status, o_item.status);
                end
            end
            if (i_valid && o_ready) begin
                expected_results.push_back(apply_edit(i_item));
                req_taken = 1'b1;
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else if (i_valid || expected_results.size() != 0) begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || req_taken) begin
                req_taken = 1'b0;
                if (gap_left > 0 || pending_reqs.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    i_valid <= 1'b0;
                end else begin
                    i_item  <= pending_reqs.pop_front();
                    i_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            if (stall_timer == 0) begin
                stall_mode  = $urandom_range(0, 3);
                stall_timer = $urandom_range(20, 100);
            end else begin
                stall_timer--;
            end
            case (stall_mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= ($urandom_range(0, 1) == 0);
                2:       i_ready <= ($urandom_range(0, 3) == 0);
                default: i_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic queue_req(logic [2:0] act, int cnt, logic [7:0] data, int idx);
        t_in_item req;
        while (pending_reqs.size() > 2) @(posedge i_clk);
        req.action     = act;
        req.count      = 13'(cnt);
        req.data_byte  = data;
        req.read_index = 12'(idx);
        pending_reqs.push_back(req);
    endtask

    function automatic logic [7:0] random_text_byte();
        return ($urandom_range(0, 6) == 0) ? NEWLINE_BYTE : 8'($urandom_range(0, 255));
    endfunction

    initial begin
        int k;
        int sel;
        int len;
        int cnt;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_item      = '0;
        mismatches  = 0;
        idle_cycles = 0;
        req_taken   = 1'b0;
        burst_left  = 0;
        gap_left    = 0;
        stall_mode  = 0;
        stall_timer = 0;
        head_len    = 0;
        right_len   = 0;
        cur_col     = 0;
        for (k = 0; k < CAP; k++) text_mem[k] = 8'h00;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty buffer: refused delete, out-of-range read, no-op moves; then edits.
        queue_req(ACT_DELETE, 0, 8'h00, 0);
        queue_req(ACT_READ, 0, 8'h00, 0);
        queue_req(ACT_LEFT, 4096, 8'h00, 0);
        queue_req(ACT_UP, 0, 8'h00, 0);
        queue_req(ACT_APPEND, 0, 8'h41, 0);
        queue_req(ACT_APPEND, 0, 8'hFF, 0);
        queue_req(ACT_APPEND, 0, NEWLINE_BYTE, 0);
        queue_req(ACT_APPEND, 0, 8'h00, 0);
        queue_req(ACT_APPEND, 0, 8'h7E, 0);
        queue_req(ACT_APPEND, 0, NEWLINE_BYTE, 0);
        queue_req(ACT_APPEND, 0, 8'h55, 0);
        queue_req(ACT_RIGHT, 1, 8'h00, 0);
        queue_req(ACT_DOWN, 0, 8'h00, 0);
        queue_req(ACT_DOWN, 0, 8'h00, 0);
        queue_req(ACT_UP, 0, 8'h00, 0);
        queue_req(ACT_RIGHT, 4096, 8'h00, 0);
        queue_req(ACT_UP, 0, 8'h00, 0);
        queue_req(ACT_INSERT, 0, 8'hAA, 0);
        queue_req(ACT_READ, 0, 8'h00, 3);
        queue_req(ACT_READ, 0, 8'h00, 4095);
        queue_req(ACT_DELETE, 0, 8'h00, 0);
        queue_req(ACT_LEFT, 2, 8'h00, 0);
        queue_req(ACT_DELETE, 0, 8'h00, 0);

        // Random editing on a short text so that moves and seeks stay cheap.
        for (k = 0; k < N_RANDOM; k++) begin
            len = head_len + right_len;
            sel = $urandom_range(0, 99);
            if (len > 200 && sel < 30) sel = 40;
            if (sel < 8) begin
                queue_req(ACT_APPEND, 0, random_text_byte(), 0);
            end else if (sel < 28) begin
                queue_req(ACT_INSERT, 0, random_text_byte(), 0);
            end else if (sel < 40) begin
                queue_req(ACT_DELETE, 0, 8'h00, 0);
            end else if (sel < 64) begin
                case ($urandom_range(0, 5))
                    0:       cnt = 4096;
                    1:       cnt = $urandom_range(0, len + 4);
                    default: cnt = $urandom_range(0, 12);
                endcase
                queue_req(($urandom_range(0, 1) == 0) ? ACT_LEFT : ACT_RIGHT, cnt,
                          8'($urandom_range(0, 255)), $urandom_range(0, 4095));
            end else if (sel < 76) begin
                queue_req(ACT_UP, $urandom_range(0, 8191), 8'($urandom_range(0, 255)), 0);
            end else if (sel < 88) begin
                queue_req(ACT_DOWN, $urandom_range(0, 8191), 8'($urandom_range(0, 255)), 0);
            end else begin
                cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                                  : $urandom_range(0, len + 2);
                queue_req(ACT_READ, 0, 8'h00, cnt);
            end
        end

        while (pending_reqs.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/gbc_pkg.sv
src/gbc_text_ram.sv
src/gbc_ctrl.sv
src/gap_buffer_cursor_engine_top.sv
dv/tb_gap_buffer_cursor_engine_top.sv
